### sv/frmsdb_pkg.sv
`default_nettype none
package frmsdb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 31;            // largest square is 2^30
  localparam int SUM_W      = 41;
  localparam int LEN_W      = 11;
  localparam int MAX_FRAME  = 1024;
  localparam logic [LEN_W-1:0] FRAME_LEN_RST = LEN_W'(1024);

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam int MEAN_W     = 31;            // mean never exceeds 2^30
  localparam int ROOT_W     = 32;
  localparam int RMS_W      = 16;
  localparam int DB_W       = 16;
  localparam int EXP_W      = 4;
  localparam int FRAC_BITS  = 24;
  localparam int LOG_W      = EXP_W + FRAC_BITS;
  localparam int MANT_W     = 31;            // Q1.30 mantissa
  localparam int DB_K_W     = 27;
  localparam logic [DB_K_W-1:0] DB_K = DB_K_W'(101008905);
  localparam int PROD_W     = LOG_W + DB_K_W;

  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = 16;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [RMS_W-1:0] RMS_FULL = RMS_W'(32768);
  localparam logic [DB_W-1:0]  DB_MIN   = DB_W'(16'h8000);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] len;
  } frame_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_RND,
    BK_NORM,
    BK_LOG,
    BK_MUL,
    BK_FIN,
    BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

### sv/frmsdb_queue.sv
`default_nettype none
module frmsdb_queue (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire frmsdb_pkg::frame_t        push_data,
  input  wire logic                      pop,
  output frmsdb_pkg::frame_t             pop_data,
  output logic                           not_empty,
  output logic [frmsdb_pkg::QCNT_W-1:0]  count
);
  import frmsdb_pkg::*;

  frame_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'((32'(wr_ptr_r) + 1) % QDEPTH) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'((32'(rd_ptr_r) + 1) % QDEPTH) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data  = slot_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule
`default_nettype wire

### sv/frmsdb_front.sv
`default_nettype none
module frmsdb_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [frmsdb_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [frmsdb_pkg::LEN_W-1:0]      frame_len,
  input  wire logic [frmsdb_pkg::QCNT_W-1:0]     q_count,
  output logic                                   push,
  output frmsdb_pkg::frame_t                     push_data
);
  import frmsdb_pkg::*;

  logic [LEN_W-1:0]    eff_len;
  logic [SAMPLE_W-1:0] mag;
  logic [LEN_W-1:0]    cnt_inc;
  logic                last_w;
  logic                accept;
  logic [QCNT_W:0]     busy_slots;

  logic [LEN_W-1:0]    count_r, count_nxt;
  logic                v1_r, v1_nxt;
  logic                last1_r;
  logic [SQ_W-1:0]     sq1_r;
  logic [LEN_W-1:0]    len1_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SUM_W-1:0]    sum_add;

  always_comb begin
    if (frame_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(frame_len) > MAX_FRAME) begin
      eff_len = LEN_W'(MAX_FRAME);
    end else begin
      eff_len = frame_len;
    end
  end

  // Hold input while the queue could not take a frame ending in flight.
  assign busy_slots = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(v1_r & last1_r);
  assign in_ready   = (32'(busy_slots) < QDEPTH);
  assign accept     = in_valid & in_ready;

  assign mag     = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
  assign cnt_inc = count_r + LEN_W'(1);
  assign last_w  = (cnt_inc >= eff_len);

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = last_w ? '0 : cnt_inc;
    end
    v1_nxt = accept;
  end

  assign sum_add = sum_r + SUM_W'(sq1_r);
  assign push    = v1_r & last1_r;
  assign push_data = '{sum: sum_add, len: len1_r};

  always_comb begin
    sum_nxt = sum_r;
    if (v1_r) begin
      sum_nxt = last1_r ? '0 : sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      v1_r    <= 1'b0;
      sum_r   <= '0;
    end else begin
      count_r <= count_nxt;
      v1_r    <= v1_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq1_r   <= SQ_W'(32'(mag) * 32'(mag));
      last1_r <= last_w;
      len1_r  <= eff_len;
    end
  end

endmodule
`default_nettype wire

### sv/frmsdb_back.sv
`default_nettype none
module frmsdb_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire frmsdb_pkg::frame_t           q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [frmsdb_pkg::RMS_W-1:0]      out_rms,
  output logic [frmsdb_pkg::DB_W-1:0]       out_db,
  output logic                              out_floor
);
  import frmsdb_pkg::*;

  bk_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [SUM_W-1:0]   quo_r;
  logic [LEN_W-1:0]   rem_r;
  logic [LEN_W-1:0]   div_r;
  logic [MEAN_W-1:0]  v_r;
  logic [ROOT_W-1:0]  root_r;
  logic [MEAN_W-1:0]  bit_r;
  logic [RMS_W-1:0]   rms_r;
  logic [EXP_W-1:0]   exp_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [MANT_W-1:0]  y_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DB_W-1:0]    db_r;
  logic               flr_r;

  logic [RMS_W-1:0]   out_rms_r;
  logic [DB_W-1:0]    out_db_r;
  logic               out_floor_r;
  logic               out_valid_r, out_valid_nxt;

  logic               out_free;
  logic               out_load;

  // divider step
  logic [LEN_W:0]     div_sh;
  logic               div_ge;
  // square root step
  logic [ROOT_W-1:0]  sq_t;
  logic               sq_ge;
  // rounding
  logic [RMS_W+1:0]   rnd;
  logic [RMS_W-1:0]   rms_w;
  // normalize
  logic [EXP_W-1:0]   exp_w;
  // log step
  logic [2*MANT_W-1:0] y_sq;
  logic [MANT_W:0]    y_sh;
  // dB finish
  logic [LOG_W-1:0]   m_w;
  logic [PROD_W:0]    prod_rnd;
  logic [DB_W-1:0]    p_w;

  assign out_free = ~out_valid_r | out_ready;

  assign div_sh = {rem_r, quo_r[SUM_W-1]};
  assign div_ge = (div_sh >= {1'b0, div_r});

  assign sq_t  = root_r + ROOT_W'(bit_r);
  assign sq_ge = (ROOT_W'(v_r) >= sq_t);

  always_comb begin
    rnd = (RMS_W+2)'(root_r[RMS_W:0]) + (RMS_W+2)'(ROOT_W'(v_r) > root_r);
    rms_w = (rnd > (RMS_W+2)'(RMS_FULL)) ? RMS_FULL : rnd[RMS_W-1:0];
  end

  always_comb begin
    exp_w = '0;
    for (int i = 0; i < RMS_W; i++) begin
      if (rms_r[i]) exp_w = EXP_W'(i);
    end
  end

  assign y_sq = (2*MANT_W)'(y_r) * (2*MANT_W)'(y_r);
  assign y_sh = y_sq[2*MANT_W-1:MANT_W-1];

  assign m_w      = LOG_W'(15 << FRAC_BITS) - {exp_r, frac_r};
  assign prod_rnd = (PROD_W+1)'(prod_r) + ((PROD_W+1)'(1) << 39);
  assign p_w      = (prod_rnd[PROD_W:40] > (PROD_W-39)'(RMS_FULL)) ? RMS_FULL
                                                                    : DB_W'(prod_rnd[PROD_W:40]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = BK_SQRT;
      BK_SQRT: if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = BK_RND;
      BK_RND:  state_nxt = (rms_w == '0) ? BK_OUT : BK_NORM;
      BK_NORM: state_nxt = BK_LOG;
      BK_LOG:  if (cnt_r == CNT_W'(FRAC_BITS - 1)) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_FIN;
      BK_FIN:  state_nxt = BK_OUT;
      BK_OUT:  if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_IDLE: q_pop    = q_valid;
      BK_OUT:  out_load = out_free;
      default: ;
    endcase
    cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + CNT_W'(1);
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        quo_r <= q_data.sum;
        div_r <= q_data.len;
        rem_r <= '0;
      end
      BK_DIV: begin
        rem_r <= div_ge ? LEN_W'(div_sh - {1'b0, div_r}) : div_sh[LEN_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], div_ge};
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          v_r    <= {quo_r[MEAN_W-2:0], div_ge};
          root_r <= '0;
          bit_r  <= MEAN_W'(1) << (MEAN_W - 1);
        end
      end
      BK_SQRT: begin
        if (sq_ge) begin
          v_r    <= MEAN_W'(ROOT_W'(v_r) - sq_t);
          root_r <= (root_r >> 1) + ROOT_W'(bit_r);
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      BK_RND: begin
        rms_r <= rms_w;
        db_r  <= DB_MIN;
        flr_r <= (rms_w == '0);
      end
      BK_NORM: begin
        exp_r  <= exp_w;
        frac_r <= '0;
        y_r    <= MANT_W'(rms_r) << (5'(30) - 5'(exp_w));
      end
      BK_LOG: begin
        // advance one fraction bit per squaring, renormalize on overflow
        frac_r <= {frac_r[FRAC_BITS-2:0], y_sh[MANT_W]};
        y_r    <= y_sh[MANT_W] ? y_sh[MANT_W:1] : y_sh[MANT_W-1:0];
      end
      BK_MUL: begin
        prod_r <= PROD_W'(m_w) * PROD_W'(DB_K);
      end
      BK_FIN: begin
        db_r <= DB_W'(0) - p_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rms_r   <= rms_r;
      out_db_r    <= db_r;
      out_floor_r <= flr_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rms   = out_rms_r;
  assign out_db    = out_db_r;
  assign out_floor = out_floor_r;

endmodule
`default_nettype wire

### sv/frame_rms_db_meter_core.sv
`default_nettype none
// Latency is shorter for a frame at the floor, which skips the log and dB steps.
// Throughput: one sample per cycle within a frame while in_tready is high; the result unit
// runs a 41-step divider, a 16-step root and 24 log squarings per frame, so frames
// shorter than that work stall in_tready once the two-entry frame queue fills.
// Reset (rst_n low, synchronous): sum, count and queue cleared, frame_length = 1024.
module frame_rms_db_meter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,     // [15:0] sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,    // [15:0] rms_level, [31:16] level_db
  output logic             out_tuser,    // [0] level_floor
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data   // frame_length
);
  import frmsdb_pkg::*;

  logic [LEN_W-1:0]  frame_len_r, frame_len_nxt;
  logic              push;
  frame_t            push_data;
  frame_t            pop_data;
  logic              pop;
  logic              q_valid;
  logic [QCNT_W-1:0] q_count;
  logic [RMS_W-1:0]  rms;
  logic [DB_W-1:0]   db;

  assign frame_len_nxt = cfg_wr_en ? cfg_wr_data : frame_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FRAME_LEN_RST;
    end else begin
      frame_len_r <= frame_len_nxt;
    end
  end

  frmsdb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .sample    (in_tdata),
    .frame_len (frame_len_r),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  frmsdb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid),
    .count     (q_count)
  );

  frmsdb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rms   (rms),
    .out_db    (db),
    .out_floor (out_tuser)
  );

  assign out_tdata = {db, rms};

endmodule
`default_nettype wire
